// ===== hw/rtl/sdiv_pkg.sv =====
// sdiv_pkg: shared types and constants for the signed restoring divider.
// No dependencies. Used by signed_restoring_divider and sdiv_checker.
package sdiv_pkg;

  localparam int unsigned ErrWidth = 2;

  typedef enum logic [ErrWidth-1:0] {
    ERR_NONE     = 2'd0,
    ERR_DIV_ZERO = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_e;

endpackage

// ===== hw/rtl/signed_restoring_divider.sv =====
// signed_restoring_divider: fully pipelined signed restoring divider.
// Throughput one item per cycle.
// One set-up stage, one restoring step per stage, one sign fix-up stage.
// busy_o never rises and the receiver cannot stall, so nothing is held back.
// rst_ni (async, active low) clears only the valid bits; data needs no reset.
// Depends on sdiv_pkg.
module signed_restoring_divider #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [DATA_WIDTH-1:0] dividend_i,
  input  logic signed [DATA_WIDTH-1:0] divisor_i,
  output logic                         valid_o,
  output logic signed [DATA_WIDTH-1:0] quotient_o,
  output logic [1:0]                   error_code_o
);

  localparam int unsigned W = DATA_WIDTH;

  // Most negative value: top bit set, rest clear.
  localparam logic [W-1:0] MinVal = {1'b1, {(W-1){1'b0}}};

  // The pipeline takes a new item every cycle, so it is never busy.
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------------
  // Valid bits. vld_q[0] goes with the set-up stage, vld_q[k+1] with division
  // step k, vld_q[W+1] with the fix-up stage that drives the outputs.
  // ---------------------------------------------------------------------------
  logic [W+1:0] vld_q;
  logic [W+1:0] vld_d;

  assign vld_d = {vld_q[W:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Data pipeline. Entry k is the input of division step k; nq_q entry W is the
  // finished magnitude. nq_q holds the numerator bits still to be consumed in
  // its upper part and the quotient bits gathered so far in its lower part:
  // every step shifts one numerator bit out at the top and one quotient bit in.
  // The remainder after the last step is not needed, so it is not registered.
  // ---------------------------------------------------------------------------
  logic [W-1:0]    nq_q  [W+1];
  logic [W-1:0]    rem_q [W];
  logic [W-1:0]    den_q [W+1];
  logic            neg_q [W+1];
  sdiv_pkg::err_e  err_q [W+1];

  // Set-up stage: magnitudes, result sign and special cases.
  logic           a_neg;
  logic           b_neg;
  logic [W-1:0]   a_mag;
  logic [W-1:0]   b_mag;
  sdiv_pkg::err_e err_d;

  always_comb begin
    a_neg = dividend_i[W-1];
    b_neg = divisor_i[W-1];
    // The most negative dividend negates to itself, which read unsigned is
    // exactly its magnitude, so no correction is needed.
    a_mag = a_neg ? (~dividend_i + 1'b1) : dividend_i;
    b_mag = b_neg ? (~divisor_i + 1'b1) : divisor_i;
    if (divisor_i == '0) begin
      err_d = sdiv_pkg::ERR_DIV_ZERO;
    end else if ((dividend_i == MinVal) && (divisor_i == {W{1'b1}})) begin
      err_d = sdiv_pkg::ERR_OVERFLOW;
    end else begin
      err_d = sdiv_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q[0]  <= a_mag;
    rem_q[0] <= '0;
    den_q[0] <= b_mag;
    neg_q[0] <= a_neg ^ b_neg;
    err_q[0] <= err_d;
  end

  // Division steps: one quotient bit per stage, top bit first.
  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W-1:0] rem_sh;
    logic [W:0]   diff;
    logic         ge;

    always_comb begin
      // Shifted remainder stays below 2^W because the remainder is below the
      // divisor magnitude, itself at most 2^(W-1).
      rem_sh = {rem_q[k][W-2:0], nq_q[k][W-1]};
      diff   = {1'b0, rem_sh} - {1'b0, den_q[k]};
      ge     = ~diff[W];
    end

    always_ff @(posedge clk_i) begin
      nq_q[k+1]  <= {nq_q[k][W-2:0], ge};
      den_q[k+1] <= den_q[k];
      neg_q[k+1] <= neg_q[k];
      err_q[k+1] <= err_q[k];
    end

    // Last step only needs the quotient bit.
    if (k < W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[k+1] <= ge ? diff[W-1:0] : rem_sh;
      end
    end
  end

  // Fix-up stage: apply the sign, force zero on error.
  logic [W-1:0] quo_d;
  logic [W-1:0] quo_q;
  logic [1:0]   err_out_q;

  always_comb begin
    if (err_q[W] != sdiv_pkg::ERR_NONE) begin
      quo_d = '0;
    end else if (neg_q[W]) begin
      quo_d = ~nq_q[W] + 1'b1;
    end else begin
      quo_d = nq_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    err_out_q <= err_q[W];
  end

  assign valid_o      = vld_q[W+1];
  assign quotient_o   = quo_q;
  assign error_code_o = err_out_q;

endmodule

// ===== hw/rtl/sdiv_checker.sv =====
// sdiv_checker: port-level assertions for signed_restoring_divider, with bind.
// Depends on sdiv_pkg and on the divider's port list.
module sdiv_checker #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic signed [DATA_WIDTH-1:0] dividend_i,
  input logic signed [DATA_WIDTH-1:0] divisor_i,
  input logic                         valid_o,
  input logic signed [DATA_WIDTH-1:0] quotient_o,
  input logic [1:0]                   error_code_o
);

  localparam int unsigned Lat = DATA_WIDTH + 2;

  // Every accepted item yields exactly one result, a fixed latency later.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Lat valid_o)
    else $error("accepted item produced no result");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##Lat !valid_o)
    else $error("result without an accepted item");

  // Any error forces a zero quotient.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (error_code_o != sdiv_pkg::ERR_NONE)) |-> (quotient_o == '0))
    else $error("non-zero quotient on error");

  // Zero divisor must be flagged.
  a_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (divisor_i == '0))
      |-> ##Lat (error_code_o == sdiv_pkg::ERR_DIV_ZERO))
    else $error("zero divisor not flagged");

  // A number divided by itself gives one, the most negative value included.
  a_self_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (divisor_i != '0) && (dividend_i == divisor_i))
      |-> ##Lat (quotient_o == DATA_WIDTH'(1)))
    else $error("x / x is not one");

endmodule

bind signed_restoring_divider sdiv_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_sdiv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .dividend_i   (dividend_i),
  .divisor_i    (divisor_i),
  .valid_o      (valid_o),
  .quotient_o   (quotient_o),
  .error_code_o (error_code_o)
);
